[hw/rtl/saop_pkg.sv]
// ----------------------------------------------------------------------------
// saop_pkg
// Types and constants shared by the sensor advertisement object parser.
// ----------------------------------------------------------------------------
package saop_pkg;

    localparam int MAC_W     = 48;
    localparam int BYTE_W    = 8;
    localparam int TEMP_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = MAC_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FILTER_ON  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MATCH_ADDR = 1'd1;

    localparam logic [BYTE_W-1:0] SERVICE_ID_LO = 8'hD2;
    localparam logic [BYTE_W-1:0] SERVICE_ID_HI = 8'hFC;

    localparam logic [BYTE_W-1:0] OBJ_PACKET_ID   = 8'h00;
    localparam logic [BYTE_W-1:0] OBJ_BATTERY     = 8'h01;
    localparam logic [BYTE_W-1:0] OBJ_HUMIDITY    = 8'h2E;
    localparam logic [BYTE_W-1:0] OBJ_BUTTON      = 8'h3A;
    localparam logic [BYTE_W-1:0] OBJ_TEMPERATURE = 8'h45;

    typedef struct packed {
        logic [BYTE_W-1:0]        data_byte;
        logic                     last_byte;
        logic [MAC_W-1:0]         source_mac;
        logic signed [BYTE_W-1:0] signal_strength;
    } in_beat_t;

    typedef struct packed {
        logic                     frame_accepted;
        logic [BYTE_W-1:0]        battery_percent;
        logic                     battery_seen;
        logic [BYTE_W-1:0]        humidity_percent;
        logic                     humidity_seen;
        logic [BYTE_W-1:0]        button_event;
        logic                     button_seen;
        logic signed [TEMP_W-1:0] temperature_tenths;
        logic                     temperature_seen;
        logic [MAC_W-1:0]         sender_address;
        logic signed [BYTE_W-1:0] frame_signal;
    } out_beat_t;

    typedef struct packed {
        logic             mac_filter_on;
        logic [MAC_W-1:0] match_addr;
    } cfg_t;

endpackage

[hw/rtl/saop_frame_parser.sv]
// ----------------------------------------------------------------------------
// saop_frame_parser
// Frame state registers and per-byte header check and object decode.
// ----------------------------------------------------------------------------
module saop_frame_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  saop_pkg::cfg_t       cfg,
    input  logic                 beat_fire,
    input  saop_pkg::in_beat_t   beat,
    output saop_pkg::out_beat_t  result
);

    typedef enum logic [1:0] {
        HDR_ID_LO,
        HDR_ID_HI,
        HDR_DEV_INFO,
        HDR_OBJECTS
    } hdr_t;

    typedef enum logic [2:0] {
        PH_ID,
        PH_SKIP,
        PH_BATT,
        PH_HUM,
        PH_BTN,
        PH_TLO,
        PH_THI,
        PH_STOP
    } phase_t;

    hdr_t                                 hdr_reg, hdr_next;
    phase_t                               phase_reg, phase_next;
    logic                                 dropped_reg, dropped_next;
    logic [saop_pkg::BYTE_W-1:0]          tlo_reg, tlo_next;
    logic [saop_pkg::BYTE_W-1:0]          batt_reg, batt_next;
    logic [saop_pkg::BYTE_W-1:0]          hum_reg, hum_next;
    logic [saop_pkg::BYTE_W-1:0]          btn_reg, btn_next;
    logic [saop_pkg::TEMP_W-1:0]          temp_reg, temp_next;
    logic [3:0]                           seen_reg, seen_next;
    logic [saop_pkg::MAC_W-1:0]           addr_reg, addr_next;
    logic [saop_pkg::BYTE_W-1:0]          sig_reg, sig_next;

    always_comb begin
        hdr_next     = hdr_reg;
        phase_next   = phase_reg;
        dropped_next = dropped_reg;
        tlo_next     = tlo_reg;
        batt_next    = batt_reg;
        hum_next     = hum_reg;
        btn_next     = btn_reg;
        temp_next    = temp_reg;
        seen_next    = seen_reg;
        addr_next    = addr_reg;
        sig_next     = sig_reg;

        case (hdr_reg)
            HDR_ID_LO: begin
                addr_next = beat.source_mac;
                sig_next  = beat.signal_strength;
                if (beat.data_byte != saop_pkg::SERVICE_ID_LO || beat.last_byte
                        || (cfg.mac_filter_on && beat.source_mac != cfg.match_addr)) begin
                    dropped_next = 1'b1;
                end
                hdr_next = HDR_ID_HI;
            end
            HDR_ID_HI: begin
                if (beat.data_byte != saop_pkg::SERVICE_ID_HI || beat.last_byte) begin
                    dropped_next = 1'b1;
                end
                hdr_next = HDR_DEV_INFO;
            end
            HDR_DEV_INFO: begin
                if (beat.data_byte[0]) begin
                    dropped_next = 1'b1;
                end
                hdr_next = HDR_OBJECTS;
            end
            default: begin
                if (!dropped_reg) begin
                    case (phase_reg)
                        PH_ID: begin
                            case (beat.data_byte)
                                saop_pkg::OBJ_PACKET_ID:   phase_next = PH_SKIP;
                                saop_pkg::OBJ_BATTERY:     phase_next = PH_BATT;
                                saop_pkg::OBJ_HUMIDITY:    phase_next = PH_HUM;
                                saop_pkg::OBJ_BUTTON:      phase_next = PH_BTN;
                                saop_pkg::OBJ_TEMPERATURE: phase_next = PH_TLO;
                                default:                   phase_next = PH_STOP;
                            endcase
                        end
                        PH_SKIP: phase_next = PH_ID;
                        PH_BATT: begin
                            batt_next    = beat.data_byte;
                            seen_next[0] = 1'b1;
                            phase_next   = PH_ID;
                        end
                        PH_HUM: begin
                            hum_next     = beat.data_byte;
                            seen_next[1] = 1'b1;
                            phase_next   = PH_ID;
                        end
                        PH_BTN: begin
                            btn_next     = beat.data_byte;
                            seen_next[2] = 1'b1;
                            phase_next   = PH_ID;
                        end
                        PH_TLO: begin
                            tlo_next   = beat.data_byte;
                            phase_next = PH_THI;
                        end
                        PH_THI: begin
                            temp_next    = {beat.data_byte, tlo_reg};
                            seen_next[3] = 1'b1;
                            phase_next   = PH_ID;
                        end
                        default: phase_next = PH_STOP;
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        result = '0;
        if (!dropped_next) begin
            result.frame_accepted     = 1'b1;
            result.battery_seen       = seen_next[0];
            result.battery_percent    = seen_next[0] ? batt_next : '0;
            result.humidity_seen      = seen_next[1];
            result.humidity_percent   = seen_next[1] ? hum_next : '0;
            result.button_seen        = seen_next[2];
            result.button_event       = seen_next[2] ? btn_next : '0;
            result.temperature_seen   = seen_next[3];
            result.temperature_tenths = seen_next[3] ? temp_next : '0;
            result.sender_address     = addr_next;
            result.frame_signal       = sig_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (beat_fire && beat.last_byte)) begin
            hdr_reg     <= HDR_ID_LO;
            phase_reg   <= PH_ID;
            dropped_reg <= 1'b0;
            tlo_reg     <= '0;
            batt_reg    <= '0;
            hum_reg     <= '0;
            btn_reg     <= '0;
            temp_reg    <= '0;
            seen_reg    <= '0;
            addr_reg    <= '0;
            sig_reg     <= '0;
        end else if (beat_fire) begin
            hdr_reg     <= hdr_next;
            phase_reg   <= phase_next;
            dropped_reg <= dropped_next;
            tlo_reg     <= tlo_next;
            batt_reg    <= batt_next;
            hum_reg     <= hum_next;
            btn_reg     <= btn_next;
            temp_reg    <= temp_next;
            seen_reg    <= seen_next;
            addr_reg    <= addr_next;
            sig_reg     <= sig_next;
        end
    end

endmodule

[hw/rtl/saop_result_buffer.sv]
// ----------------------------------------------------------------------------
// saop_result_buffer
// Output register with one skid stage for result beats.
// ----------------------------------------------------------------------------
module saop_result_buffer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  saop_pkg::out_beat_t  push_data,
    output logic                 has_room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output saop_pkg::out_beat_t  m_data
);

    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    saop_pkg::out_beat_t  out_data_reg;
    saop_pkg::out_beat_t  skid_data_reg;
    logic                 pop;

    assign pop      = out_valid_reg && m_ready;
    assign has_room = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

endmodule

[hw/rtl/sensor_advert_object_parser_top.sv]
// ----------------------------------------------------------------------------
// sensor_advert_object_parser_top
// Byte-stream parser for plaintext sensor advertisement service data.
// ----------------------------------------------------------------------------
// Input channel s_*: one service-data byte per beat, starting at the two
// identifier bytes, with the sender address and signal strength alongside;
// s_data.last_byte marks the final byte of the frame.
// Result channel m_*: one beat per frame, issued for the byte marked last,
// carrying the decoded objects, the seen flags and the latched sender data.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (0 = address filter enable, 1 = target address) at the clock edge.
// Throughput: one byte per cycle while s_ready is high; the frame state update
// is a single pass of logic between the frame state registers. Latency: the
// result beat is valid the cycle after the last byte is taken if the output
// register is empty or being read, else it waits in the skid entry. These
// two entries keep s_ready high while one waits, dropping it only when full.
// Reset (aresetn low, synchronous): frame state, filter enable and target
// address clear, and the result buffer empties.
// ----------------------------------------------------------------------------
module sensor_advert_object_parser_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [saop_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [saop_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  saop_pkg::in_beat_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output saop_pkg::out_beat_t                 m_data
);

    saop_pkg::cfg_t       cfg_reg;
    saop_pkg::out_beat_t  result;
    logic                 beat_fire;

    assign beat_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                saop_pkg::CFG_IDX_FILTER_ON:  cfg_reg.mac_filter_on <= cfg_wdata[0];
                saop_pkg::CFG_IDX_MATCH_ADDR: cfg_reg.match_addr    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    saop_frame_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .beat_fire (beat_fire),
        .beat      (s_data),
        .result    (result)
    );

    saop_result_buffer u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (beat_fire && s_data.last_byte),
        .push_data (result),
        .has_room  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[hw/rtl/saop_checker.sv]
// ----------------------------------------------------------------------------
// saop_checker
// Port-level assertions for the sensor advertisement object parser.
// ----------------------------------------------------------------------------
module saop_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_ready,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  saop_pkg::out_beat_t  m_data
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

    a_dropped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.frame_accepted |-> m_data == '0)
        else $error("dropped frame result carries nonzero fields");

    a_seen_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.battery_seen || m_data.battery_percent == '0)
                 && (m_data.humidity_seen || m_data.humidity_percent == '0)
                 && (m_data.button_seen || m_data.button_event == '0)
                 && (m_data.temperature_seen || m_data.temperature_tenths == '0))
        else $error("value reported without its seen flag");

endmodule

bind sensor_advert_object_parser_top saop_checker u_saop_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
